// ----- rtl/core/vmmc_pkg.sv -----
// ----------------------------------------------------------------------------
// vmmc_pkg
// shared types and constants of the visibility map minimum composite block
// ----------------------------------------------------------------------------
package vmmc_pkg;

    // payload lanes carried by one transfer, one signed byte each
    localparam int PAYLOAD_LANES = 8;
    localparam int PAYLOAD_W     = 64;

    // opaque value, also the reset value of every explored byte
    localparam logic signed [7:0] OPAQUE = 8'sd127;
    localparam logic [PAYLOAD_W-1:0] ALL_OPAQUE = 64'h7F7F_7F7F_7F7F_7F7F;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WORDS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPL_WEIGHT = 2'd2;

    // register reset values
    localparam int RST_ROW_WORDS = 32;
    localparam int RST_ROW_COUNT = 256;
    localparam logic [7:0] RST_EXPL_WEIGHT = 8'd35;

    typedef struct packed {
        logic [7:0]           row_index;
        logic [4:0]           word_column;
        logic [PAYLOAD_W-1:0] visible_bytes;
    } t_in_item;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] summary_bytes;
        logic [PAYLOAD_W-1:0] explored_bytes;
    } t_out_item;

    // where the word sits on the map
    typedef struct packed {
        logic in_map;
        logic edge_row;
        logic first_word;
        logic last_word;
    } t_pos_flags;

endpackage

// ----- rtl/core/visibility_map_min_composite.sv -----
// ----------------------------------------------------------------------------
// visibility_map_min_composite
// pipeline: registered store read, lane register, merge register
// throughput: one word per cycle when the output does not stall and the
//   clear sweep is done; the explored store is read and written once
//   per word (one read port, one write port) with a forward path for repeats
// reset: config returns to 32 words, 256 rows, explored weight 35; the store
//   is then swept to 127 with input stalled
// ----------------------------------------------------------------------------
module visibility_map_min_composite #(
    parameter int MAX_ROW_WORDS = 32,
    parameter int MAX_ROWS      = 256,
    parameter int LANES         = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    input  vmmc_pkg::t_in_item              i_in_data,
    output logic                            o_in_stall,
    // output channel
    output logic                            o_out_valid,
    output vmmc_pkg::t_out_item             o_out_data,
    input  logic                            i_out_stall,
    // configuration write channel
    input  logic                            i_cfg_valid,
    input  logic [vmmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vmmc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_cfg_ready
);
    import vmmc_pkg::*;

    // only the low payload lanes are processed
    localparam int EFF_LANES = (LANES > PAYLOAD_LANES) ? PAYLOAD_LANES : LANES;
    localparam int STORE_W   = EFF_LANES * 8;
    localparam int DEPTH     = MAX_ROWS * MAX_ROW_WORDS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WM1_W     = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;
    localparam int RM1_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // clamp a size register into 1..max and return the value minus one
    function automatic int eff_m1(input int value, input int max_val);
        int v;
        v = (value < 1) ? 1 : ((value > max_val) ? max_val : value);
        return v - 1;
    endfunction

    // ---------------------------------------------------------------- config
    // sizes are kept as last index, clamped when written
    logic [WM1_W-1:0] r_words_m1;
    logic [RM1_W-1:0] r_rows_m1;
    logic [7:0]       r_expl_weight;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_m1    <= WM1_W'(eff_m1(RST_ROW_WORDS, MAX_ROW_WORDS));
            r_rows_m1     <= RM1_W'(eff_m1(RST_ROW_COUNT, MAX_ROWS));
            r_expl_weight <= RST_EXPL_WEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROW_WORDS: begin
                    r_words_m1 <= WM1_W'(eff_m1(int'(i_cfg_data[5:0]), MAX_ROW_WORDS));
                end
                CFG_ROW_COUNT: begin
                    r_rows_m1 <= RM1_W'(eff_m1(int'(i_cfg_data), MAX_ROWS));
                end
                CFG_EXPL_WEIGHT: begin
                    r_expl_weight <= i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------- clear sweep
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (32'(r_clr_addr) == DEPTH - 1) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ------------------------------------------------------- pipeline control
    // stage a: store read data arrives, new explored word written back
    // stage b: lane multipliers; out: merge register
    logic r_a_v;
    logic r_b_v;
    logic r_out_v;
    logic out_ready;
    logic b_ready;
    logic a_ready;
    logic a_fire;
    logic in_xfer;

    assign out_ready  = !r_out_v || !i_out_stall;
    assign b_ready    = !r_b_v || out_ready;
    assign a_ready    = !r_a_v || b_ready;
    assign a_fire     = r_a_v && b_ready;
    assign o_in_stall = r_clearing || !a_ready;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_v <= in_xfer;
            end
            if (b_ready) begin
                r_b_v <= r_a_v;
            end
            if (out_ready) begin
                r_out_v <= r_b_v;
            end
        end
    end

    assign o_out_valid = r_out_v;

    // ------------------------------------------------------- position decode
    t_pos_flags        in_flags;
    logic [ADDR_W-1:0] in_addr;

    always_comb begin
        in_flags.in_map     = (16'(i_in_data.row_index) <= 16'(r_rows_m1)) &&
                              (16'(i_in_data.word_column) <= 16'(r_words_m1));
        in_flags.edge_row   = (i_in_data.row_index == 8'd0) ||
                              (16'(i_in_data.row_index) == 16'(r_rows_m1));
        in_flags.first_word = (i_in_data.word_column == 5'd0);
        in_flags.last_word  = (16'(i_in_data.word_column) == 16'(r_words_m1));
    end

    // row-major word address
    assign in_addr = ADDR_W'(32'(i_in_data.row_index) * 32'(MAX_ROW_WORDS) +
                             32'(i_in_data.word_column));

    // -------------------------------------------------------------- stage a
    t_pos_flags         r_a_flags;
    logic [ADDR_W-1:0]  r_a_addr;
    logic [STORE_W-1:0] r_a_vis;
    logic               r_a_fwd;
    logic [STORE_W-1:0] r_a_fwd_data;
    t_pos_flags         r_b_flags;

    logic [STORE_W-1:0] ram_rdata;
    logic [STORE_W-1:0] old_word;
    logic [STORE_W-1:0] expl_a;
    logic [STORE_W-1:0] expl_b;
    logic [STORE_W-1:0] summ_b;
    logic               wr_en;

    // write back happens when stage a hands its word on
    assign wr_en = a_fire && r_a_flags.in_map;

    // a word read in the same cycle that its address is written back
    // gets the written value, since the ram returns the old contents
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_flags    <= in_flags;
            r_a_addr     <= in_addr;
            r_a_vis      <= i_in_data.visible_bytes[STORE_W-1:0];
            r_a_fwd      <= wr_en && (r_a_addr == in_addr);
            r_a_fwd_data <= expl_a;
        end
        if (a_fire) begin
            r_b_flags <= r_a_flags;
        end
    end

    assign old_word = r_a_fwd ? r_a_fwd_data : ram_rdata;

    // explored store; the clear sweep owns the write port after reset
    vmmc_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_clearing || wr_en),
        .i_waddr (r_clearing ? r_clr_addr : r_a_addr),
        .i_wdata (r_clearing ? {EFF_LANES{OPAQUE}} : expl_a),
        .i_re    (in_xfer),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------ the lanes
    for (genvar k = 0; k < EFF_LANES; k++) begin : g_lane
        vmmc_lane u_lane (
            .i_clk         (i_clk),
            .i_load        (a_fire),
            .i_expl_weight (r_expl_weight),
            .i_vis         (r_a_vis[k*8 +: 8]),
            .i_old         (old_word[k*8 +: 8]),
            .o_expl_a      (expl_a[k*8 +: 8]),
            .o_expl_b      (expl_b[k*8 +: 8]),
            .o_summ_b      (summ_b[k*8 +: 8])
        );
    end

    // ------------------------------------------------------- merge / output
    // border forcing and out-of-map words are settled here
    vmmc_merge #(
        .NUM_LANES (EFF_LANES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_load  (r_b_v && out_ready),
        .i_flags (r_b_flags),
        .i_summ  (summ_b),
        .i_expl  (expl_b),
        .o_item  (o_out_data)
    );

endmodule

// ----- rtl/core/vmmc_ram.sv -----
// ----------------------------------------------------------------------------
// vmmc_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module vmmc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/vmmc_lane.sv -----
// ----------------------------------------------------------------------------
// vmmc_lane
// one byte lane: explored minimum, then weighted composite
// ----------------------------------------------------------------------------
module vmmc_lane (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic [7:0]        i_expl_weight,
    input  logic signed [7:0] i_vis,
    input  logic signed [7:0] i_old,
    output logic signed [7:0] o_expl_a,
    output logic signed [7:0] o_expl_b,
    output logic signed [7:0] o_summ_b
);
    import vmmc_pkg::*;

    logic signed [7:0] expl;
    logic signed [8:0] diff;
    logic [7:0]        r_d;
    logic signed [7:0] r_vis;
    logic signed [7:0] r_expl;
    logic [15:0]       prod;
    logic [7:0]        c_raw;
    logic [6:0]        c_sat;
    logic signed [7:0] s_lim;

    // first stage: new explored value and its distance from opaque
    assign expl     = (i_vis < i_old) ? i_vis : i_old;
    assign diff     = 9'sd127 - {expl[7], expl};
    assign o_expl_a = expl;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_d    <= diff[7:0];
            r_vis  <= i_vis;
            r_expl <= expl;
        end
    end

    // second stage: full product, saturate, take the minimum
    assign prod  = r_d * i_expl_weight;
    assign c_raw = prod[15:8];
    assign c_sat = (c_raw > 8'd127) ? 7'd127 : c_raw[6:0];
    assign s_lim = OPAQUE - $signed({1'b0, c_sat});

    assign o_summ_b = (r_vis < s_lim) ? r_vis : s_lim;
    assign o_expl_b = r_expl;

endmodule

// ----- rtl/core/vmmc_merge.sv -----
// ----------------------------------------------------------------------------
// vmmc_merge
// gathers the lane results, applies the border rule, output register
// ----------------------------------------------------------------------------
module vmmc_merge #(
    parameter int NUM_LANES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  vmmc_pkg::t_pos_flags        i_flags,
    input  logic [NUM_LANES*8-1:0]      i_summ,
    input  logic [NUM_LANES*8-1:0]      i_expl,
    output vmmc_pkg::t_out_item         o_item
);
    import vmmc_pkg::*;

    logic [NUM_LANES*8-1:0] summ_forced;
    t_out_item              n_item;
    t_out_item              r_item;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            if (i_flags.edge_row || (i_flags.first_word && k == 0) ||
                (i_flags.last_word && k == NUM_LANES - 1)) begin
                summ_forced[k*8 +: 8] = OPAQUE;
            end else begin
                summ_forced[k*8 +: 8] = i_summ[k*8 +: 8];
            end
        end
    end

    always_comb begin
        if (i_flags.in_map) begin
            n_item.summary_bytes  = PAYLOAD_W'(summ_forced);
            n_item.explored_bytes = PAYLOAD_W'(i_expl);
        end else begin
            n_item.summary_bytes  = ALL_OPAQUE;
            n_item.explored_bytes = ALL_OPAQUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives eight-lane visibility words into the minimum composite block while
// both channels idle and stall at random, and checks each result word against
// a local predictor. The predictor keeps its own explored map and register
// copies. Directed words cover the map border, off-map positions and register
// saturation, and random phases then cycle through register settings.
// ----------------------------------------------------------------------------
module testbench;
    import vmmc_pkg::*;

    localparam int MAP_WORDS      = 32;
    localparam int MAP_ROWS       = 256;
    localparam int MAP_DEPTH      = MAP_WORDS * MAP_ROWS;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 135;
    // covers the clearing sweep after reset with a wide margin
    localparam int WATCHDOG_LIMIT = 30000;

    // index with no register behind it, writes there are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } stall_mode_e;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_ROW_WORDS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_cfg_ready;

    visibility_map_min_composite uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copies of the registers and the explored map
    logic [5:0]  reg_row_words = 6'd32;
    logic [8:0]  reg_row_count = 9'd256;
    logic [7:0]  reg_expl_weight = RST_EXPL_WEIGHT;
    logic [63:0] explored_mem [MAP_DEPTH];

    t_in_item  item_q[$];       // words waiting to be driven
    t_out_item composite_q[$];  // predicted results, oldest first
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    logic      in_xfer = 1'b0;  // input transfer at the last rising edge

    // sender burst shaping
    int burst_left = 0;
    int gap_left = 0;

    // receiver stall shaping
    stall_mode_e stall_mode = STALL_NONE;
    int          stall_left = 0;
    logic [7:0]  stall_pat = '0;

    // last position sent, reused to hit the read-after-write path
    int last_row = 0;
    int last_col = 0;

    // register values saturate into the map size
    function automatic int map_words();
        if (reg_row_words == 0) return 1;
        if (int'(reg_row_words) > MAP_WORDS) return MAP_WORDS;
        return int'(reg_row_words);
    endfunction

    function automatic int map_rows();
        if (reg_row_count == 0) return 1;
        if (int'(reg_row_count) > MAP_ROWS) return MAP_ROWS;
        return int'(reg_row_count);
    endfunction

    // updates the explored map and returns the composite for one word
    function automatic t_out_item predict_composite(t_in_item word);
        t_out_item   res;
        logic [63:0] prior;
        int          words, rows, row, col, addr, k, v, e, c, s;
        logic        at_edge;
        words = map_words();
        rows  = map_rows();
        row   = int'(word.row_index);
        col   = int'(word.word_column);
        res.summary_bytes  = ALL_OPAQUE;
        res.explored_bytes = ALL_OPAQUE;
        // off the map: store untouched, all lanes opaque
        if (row >= rows || col >= words) return res;
        addr    = row * MAP_WORDS + col;
        prior   = explored_mem[addr];
        at_edge = (row == 0) || (row == rows - 1);
        for (k = 0; k < PAYLOAD_LANES; k++) begin
            v = $signed(word.visible_bytes[8*k +: 8]);
            e = $signed(prior[8*k +: 8]);
            if (v < e) e = v;
            // explored weight uses the full product, never wraps
            c = ((127 - e) * int'(reg_expl_weight)) >>> 8;
            if (c > 127) c = 127;
            s = 127 - c;
            if (v < s) s = v;
            // map border stays opaque in the summary only
            if (at_edge || (col == 0 && k == 0) ||
                (col == words - 1 && k == PAYLOAD_LANES - 1)) begin
                s = 127;
            end
            res.explored_bytes[8*k +: 8] = e[7:0];
            res.summary_bytes[8*k +: 8]  = s[7:0];
        end
        explored_mem[addr] = res.explored_bytes;
        return res;
    endfunction

    // input driver: bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_xfer) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (item_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= item_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        // otherwise the stalled transfer holds its payload
    end

    // receiver stall: modes that last for random stretches
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_e'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
            stall_pat  = 8'($urandom_range(0, 255));
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:    i_out_stall <= 1'b0;
            STALL_LIGHT:   i_out_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY:   i_out_stall <= ($urandom_range(0, 99) < 75);
            STALL_PATTERN: i_out_stall <= stall_pat[stall_left % 8];
            default:       i_out_stall <= 1'b0;
        endcase
    end

    // predictor on input transfers, checker on output transfers
    always @(posedge i_clk) begin
        t_out_item want;
        in_xfer <= i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0) begin
            composite_q.push_back(predict_composite(i_in_data));
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (composite_q.size() == 0) begin
                $display("%0t: result with no pending expectation, actual %h",
                         $time, o_out_data);
                mismatch_count++;
            end else begin
                want = composite_q.pop_front();
                if (o_out_data.summary_bytes !== want.summary_bytes) begin
                    $display("%0t: summary_bytes mismatch, expected %h, actual %h",
                             $time, want.summary_bytes, o_out_data.summary_bytes);
                    mismatch_count++;
                end
                if (o_out_data.explored_bytes !== want.explored_bytes) begin
                    $display("%0t: explored_bytes mismatch, expected %h, actual %h",
                             $time, want.explored_bytes, o_out_data.explored_bytes);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_item(input int row, input int col, input logic [63:0] vis);
        t_in_item word;
        word.row_index     = row[7:0];
        word.word_column   = col[4:0];
        word.visible_bytes = vis;
        item_q.push_back(word);
        last_row = row;
        last_col = col;
    endtask

    function automatic logic [63:0] random_opacity();
        logic [63:0] vis;
        int          k;
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        for (k = 0; k < PAYLOAD_LANES; k++) begin
            case ($urandom_range(0, 7))
                0:       vis[8*k +: 8] = 8'h80;
                1:       vis[8*k +: 8] = 8'h7F;
                2:       vis[8*k +: 8] = 8'h00;
                3:       vis[8*k +: 8] = 8'hFF;
                default: vis[8*k +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return vis;
    endfunction

    // mostly on-map words, with runs at the same or neighboring position
    task automatic queue_random_item();
        int row, col, pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            row = $urandom_range(0, 255);
            col = $urandom_range(0, 31);
        end else if (pick < 35) begin
            row = last_row;
            col = last_col;
        end else if (pick < 45) begin
            row = last_row;
            col = (last_col == 0) ? 0 : last_col - 1;
        end else begin
            row = $urandom_range(0, map_rows() - 1);
            col = $urandom_range(0, map_words() - 1);
        end
        queue_item(row, col, random_opacity());
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_ROW_WORDS:   reg_row_words = data[5:0];
            CFG_ROW_COUNT:   reg_row_count = data[8:0];
            CFG_EXPL_WEIGHT: reg_expl_weight = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until the queue is empty and every predicted result is back
    task automatic drain_block();
        while (item_q.size() != 0 || i_in_valid || composite_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        int          p, n;
        logic [8:0]  cfg_val;
        for (n = 0; n < MAP_DEPTH; n++) explored_mem[n] = ALL_OPAQUE;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: border, repeats at one position, sign extremes
        queue_item(0, 0, 64'h8080_8080_8080_8080);
        queue_item(255, 31, 64'h8080_8080_8080_8080);
        queue_item(1, 0, 64'h8080_8080_8080_8080);
        queue_item(1, 31, 64'h8080_8080_8080_8080);
        queue_item(7, 9, 64'h7F7F_7F7F_7F7F_7F7F);
        queue_item(7, 9, 64'h8080_8080_8080_8080);
        queue_item(7, 9, 64'h7F7F_7F7F_7F7F_7F7F);
        queue_item(8, 9, 64'h807F_00FF_017E_C03F);
        queue_item(8, 9, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_item(200, 16, {$urandom, $urandom});
        drain_block();

        // full weight: explored opacity takes the whole summary down
        write_reg(CFG_EXPL_WEIGHT, 9'd255);
        queue_item(7, 9, 64'h7F7F_7F7F_7F7F_7F7F);
        queue_item(20, 3, 64'h0000_0000_0000_0000);
        drain_block();
        write_reg(CFG_EXPL_WEIGHT, 9'd0);
        queue_item(7, 9, 64'h7F7F_7F7F_7F7F_7F7F);
        drain_block();

        // small map, row_words data above bit 5 is dropped
        write_reg(CFG_ROW_WORDS, 9'h044);
        write_reg(CFG_ROW_COUNT, 9'd10);
        write_reg(CFG_EXPL_WEIGHT, 9'd200);
        queue_item(10, 0, 64'h8080_8080_8080_8080);
        queue_item(3, 4, 64'h8080_8080_8080_8080);
        queue_item(9, 2, 64'h0101_0101_0101_0101);
        queue_item(4, 3, 64'h8080_8080_8080_8080);
        queue_item(4, 0, 64'hC0C0_C0C0_C0C0_C0C0);
        queue_item(255, 31, 64'h8080_8080_8080_8080);
        drain_block();

        // zero sizes saturate to a one-word map
        write_reg(CFG_ROW_WORDS, 9'd0);
        write_reg(CFG_ROW_COUNT, 9'd0);
        queue_item(0, 0, 64'h8000_7FFF_0180_7F00);
        queue_item(0, 1, 64'h8080_8080_8080_8080);
        queue_item(1, 0, 64'h8080_8080_8080_8080);
        drain_block();

        // oversized values saturate to the full map, unused index ignored
        write_reg(CFG_ROW_WORDS, 9'd63);
        write_reg(CFG_ROW_COUNT, 9'd511);
        write_reg(CFG_UNUSED, 9'h1FF);
        queue_item(255, 31, 64'h9090_9090_9090_9090);
        queue_item(254, 31, 64'h9090_9090_9090_9090);
        drain_block();

        // random phases, each under its own register setting
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       cfg_val = 9'd1;
                1:       cfg_val = 9'd32;
                2:       cfg_val = 9'd0;
                3:       cfg_val = 9'($urandom_range(0, 511));
                default: cfg_val = 9'($urandom_range(1, 32));
            endcase
            write_reg(CFG_ROW_WORDS, cfg_val);
            case ($urandom_range(0, 5))
                0:       cfg_val = 9'd1;
                1:       cfg_val = 9'd256;
                2:       cfg_val = 9'd2;
                3:       cfg_val = 9'($urandom_range(0, 511));
                default: cfg_val = 9'($urandom_range(1, 256));
            endcase
            write_reg(CFG_ROW_COUNT, cfg_val);
            case ($urandom_range(0, 4))
                0:       cfg_val = 9'd0;
                1:       cfg_val = 9'd255;
                2:       cfg_val = 9'($urandom_range(127, 130));
                default: cfg_val = 9'($urandom_range(0, 511));
            endcase
            write_reg(CFG_EXPL_WEIGHT, cfg_val);
            if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 9'($urandom_range(0, 511)));
            for (n = 0; n < PHASE_ITEMS; n++) queue_random_item();
            drain_block();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && composite_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
